@@ hdl/sm3_pkg.sv @@
package sm3_pkg;

	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h7a879d8a;

	localparam logic [255:0] IV =
		256'h7380166F4914B2B9172442D7DA8A0600A96F30BC163138AAE38DEE4DB0FB0E4E;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		begin
			d = {x, x} << n;
			rotl = d[63:32];
		end
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		perm0 = x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		perm1 = x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

endpackage

@@ hdl/sm3_round.sv @@
// One compression round, reused for all 64 rounds of a block.
module sm3_round (
	input  logic [255:0] v,
	input  logic [5:0]   j,
	input  logic [31:0]  wj,
	input  logic [31:0]  wj4,
	output logic [255:0] v_next
);
	import sm3_pkg::*;

	logic [31:0] a, b, c, d, e, f, g, h;
	logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;
	logic        hi;

	always_comb begin
		{a, b, c, d, e, f, g, h} = v;
		hi  = (j > 6'd15);
		t   = hi ? T_HIGH : T_LOW;
		a12 = rotl(a, 5'd12);
		ss1 = rotl(a12 + e + rotl(t, j[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		ff  = hi ? ((a & b) | (b & c) | (a & c)) : (a ^ b ^ c);
		gg  = hi ? ((e & f) | (~e & g)) : (e ^ f ^ g);
		tt1 = ff + d + ss2 + (wj ^ wj4);
		tt2 = gg + h + ss1 + wj;
		v_next = {tt1, a, rotl(b, 5'd9), c, perm0(tt2), e, rotl(f, 5'd19), g};
	end
endmodule

@@ hdl/sm3_hash_engine.sv @@
// Streaming SM3 hash engine.
// Input channel (valid/ready): one 32-bit message word per item, first nibble
// in bits 31..28. The item flagged last_word carries nibble_count valid
// nibbles (0..8, more count as 8) and triggers padding and the digest.
// Output channel (valid/ready): eight digest words, word_index 0 first,
// digest_last high on the eighth.
// A word that completes a 512-bit block starts 64 compression rounds, one
// per cycle through a single round unit, and then folds the result into the
// chaining value. The message window is a 16-word shift line whose head
// supplies W[j] and W[j+4]; it expands one word per round.
// On a last word the padding words are fed in one per cycle, with one or two
// compressions, after which the eight digest words are shown one at a time.
// A stalled receiver holds the current digest word; no input is taken until
// all eight have gone.
// Reset loads the SM3 initial value, clears the length and the position.
module sm3_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [31:0] data_word,
	input  logic [3:0]  nibble_count,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        digest_last
);
	import sm3_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RND  = 3'd1;
	localparam logic [2:0] ST_FOLD = 3'd2;
	localparam logic [2:0] ST_PAD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]   state_q;
	logic [255:0] cv_q, v_q, v_next;
	logic [31:0]  win_q [0:15];
	logic [63:0]  len_q;
	logic [3:0]   pos_q;
	logic [5:0]   rnd_q;
	logic         pad_q;      // padding in progress
	logic         extra_q;    // a bare 0x80000000 word is still owed
	logic         fin_q;      // the length words are in the window
	logic [2:0]   oidx_q;
	logic [3:0]   cnt;
	logic [5:0]   sh;
	logic [31:0]  mask, pw, push_w, nw;
	logic [63:0]  len_fin;
	logic         push;

	sm3_round u_round (
		.v(v_q), .j(rnd_q), .wj(win_q[0]), .wj4(win_q[4]), .v_next(v_next)
	);

	assign ready       = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = cv_q[255 - 32*oidx_q -: 32];
	assign word_index  = oidx_q;
	assign digest_last = (oidx_q == 3'd7);

	always_comb begin
		cnt  = (nibble_count > 4'd8) ? 4'd8 : nibble_count;
		sh   = 6'd32 - {cnt, 2'b00};
		mask = (cnt == 4'd0) ? 32'd0 : ~((32'd1 << sh) - 32'd1);
		pw   = (cnt == 4'd8) ? data_word : ((data_word & mask) | (32'h80000000 >> {cnt, 2'b00}));
		len_fin = len_q + {58'd0, cnt, 2'b00};
		// Expanded word W[j+16] from the window head.
		nw = perm1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 5'd15))
			^ rotl(win_q[3], 5'd7) ^ win_q[10];
		push = 1'b0;
		push_w = 32'd0;
		if (state_q == ST_IDLE && valid) begin
			push = 1'b1;
			push_w = last_word ? pw : data_word;
		end else if (state_q == ST_PAD) begin
			push = 1'b1;
			if (extra_q) push_w = 32'h80000000;
			else if (pos_q == 4'd14) push_w = len_q[63:32];
			else if (pos_q == 4'd15 && fin_q) push_w = len_q[31:0];
			else push_w = 32'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			win_q[pos_q] <= push_w;
			if (pos_q == 4'd15) v_q <= cv_q;
		end else if (state_q == ST_RND) begin
			v_q <= v_next;
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= nw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cv_q    <= IV;
			len_q   <= 64'd0;
			pos_q   <= 4'd0;
			rnd_q   <= 6'd0;
			pad_q   <= 1'b0;
			extra_q <= 1'b0;
			fin_q   <= 1'b0;
			oidx_q  <= 3'd0;
		end else begin
			if (push) pos_q <= pos_q + 4'd1;
			unique case (state_q)
				ST_IDLE: begin
					if (valid) begin
						if (last_word) begin
							len_q   <= len_fin;
							pad_q   <= 1'b1;
							extra_q <= (cnt == 4'd8);
						end else begin
							len_q <= len_q + 64'd32;
						end
						if (pos_q == 4'd15) state_q <= ST_RND;
						else if (last_word) state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					extra_q <= 1'b0;
					if (pos_q == 4'd14 && !extra_q) fin_q <= 1'b1;
					if (pos_q == 4'd15) state_q <= ST_RND;
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					cv_q <= cv_q ^ v_q;
					if (!pad_q) state_q <= ST_IDLE;
					else if (fin_q) state_q <= ST_OUT;
					else state_q <= ST_PAD;
				end
				ST_OUT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							state_q <= ST_IDLE;
							cv_q    <= IV;
							len_q   <= 64'd0;
							pad_q   <= 1'b0;
							fin_q   <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ test/sm3_hash_engine_tb.sv @@
module sm3_hash_engine_tb;
	import sm3_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [3:0]  nibble_count;
	logic        last_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        digest_last;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        fin;
	} digest_item_t;

	// Independent SM3 predictor with its own chaining value and block buffer.
	class sm3_scoreboard;
		logic [31:0]  chain[8];
		logic [31:0]  block_buf[16];
		logic [63:0]  msg_bits;
		int unsigned  fill;
		digest_item_t pending_digest[$];
		int unsigned  errors;
		int unsigned  digests_seen;
		int unsigned  words_taken;

		function void start_message();
			for (int i = 0; i < 8; i++)
				chain[i] = IV[255 - 32*i -: 32];
			msg_bits = '0;
			fill = 0;
		endfunction

		function logic [31:0] rol(logic [31:0] x, int n);
			n = n % 32;
			if (n == 0)
				return x;
			return (x << n) | (x >> (32 - n));
		endfunction

		function void compress_block();
			logic [31:0] w[68];
			logic [31:0] v[8];
			logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2;
			for (int i = 0; i < 16; i++)
				w[i] = block_buf[i];
			for (int i = 16; i < 68; i++) begin
				t = w[i-16] ^ w[i-9] ^ rol(w[i-3], 15);
				w[i] = t ^ rol(t, 15) ^ rol(t, 23) ^ rol(w[i-13], 7) ^ w[i-6];
			end
			for (int i = 0; i < 8; i++)
				v[i] = chain[i];
			for (int j = 0; j < 64; j++) begin
				t = (j > 15) ? 32'h7a879d8a : 32'h79cc4519;
				a12 = rol(v[0], 12);
				ss1 = rol(a12 + v[4] + rol(t, j), 7);
				ss2 = ss1 ^ a12;
				ff = (j > 15) ? ((v[0] & v[1]) | (v[1] & v[2]) | (v[0] & v[2]))
					: (v[0] ^ v[1] ^ v[2]);
				gg = (j > 15) ? ((v[4] & v[5]) | (~v[4] & v[6])) : (v[4] ^ v[5] ^ v[6]);
				tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
				tt2 = gg + v[7] + ss1 + w[j];
				v[3] = v[2];
				v[2] = rol(v[1], 9);
				v[1] = v[0];
				v[0] = tt1;
				v[7] = v[6];
				v[6] = rol(v[5], 19);
				v[5] = v[4];
				v[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
			end
			for (int i = 0; i < 8; i++)
				chain[i] ^= v[i];
		endfunction

		function void append_word(logic [31:0] x);
			block_buf[fill] = x;
			fill = (fill + 1) % 16;
			if (fill == 0)
				compress_block();
		endfunction

		function void note_word(logic [31:0] d, logic [3:0] n, logic lst);
			int unsigned cnt;
			logic [31:0] mask;
			logic [63:0] total;
			digest_item_t e;
			words_taken++;
			if (!lst) begin
				msg_bits += 32;
				append_word(d);
				return;
			end
			cnt = (n > 8) ? 8 : n;
			msg_bits += 4 * cnt;
			total = msg_bits;
			if (cnt == 8) begin
				append_word(d);
				append_word(32'h80000000);
			end else begin
				mask = (cnt == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 4*cnt));
				append_word((d & mask) | (32'h80000000 >> (4*cnt)));
			end
			while (fill != 14)
				append_word(32'h0);
			append_word(total[63:32]);
			append_word(total[31:0]);
			for (int i = 0; i < 8; i++) begin
				e.word = chain[i];
				e.idx = 3'(i);
				e.fin = (i == 7);
				pending_digest.push_back(e);
			end
			start_message();
		endfunction

		function void check_digest(logic [31:0] dw, logic [2:0] ix, logic dl);
			digest_item_t e;
			if (pending_digest.size() == 0) begin
				$display("%0t: unexpected digest word %h idx %0d last %0b",
					$time, dw, ix, dl);
				errors++;
				return;
			end
			e = pending_digest.pop_front();
			if (dw !== e.word) begin
				$display("%0t: digest_word expected %h actual %h", $time, e.word, dw);
				errors++;
			end
			if (ix !== e.idx) begin
				$display("%0t: word_index expected %0d actual %0d", $time, e.idx, ix);
				errors++;
			end
			if (dl !== e.fin) begin
				$display("%0t: digest_last expected %0b actual %0b", $time, e.fin, dl);
				errors++;
			end
			if (dl === 1'b1)
				digests_seen++;
		endfunction
	endclass

	sm3_scoreboard sb;
	int unsigned   idle_cycles = 0;
	int unsigned   hold_off = 0;
	bit            stall_go = 1'b0;
	bit            stall_done = 1'b0;
	bit            calm_phase;
	bit            timed_out = 1'b0;

	sm3_hash_engine uut (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.data_word(data_word), .nibble_count(nibble_count), .last_word(last_word),
		.out_valid(out_valid), .out_ready(out_ready), .digest_word(digest_word),
		.word_index(word_index), .digest_last(digest_last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offers one item and waits for its acceptance; may idle first.
	task automatic send_word(logic [31:0] d, logic [3:0] n, logic lst);
		if (!calm_phase && $urandom_range(99) < 6) begin
			valid <= 1'b0;
			@(posedge clk);
			while (!calm_phase && $urandom_range(99) < 6)
				@(posedge clk);
		end
		valid <= 1'b1;
		data_word <= d;
		nibble_count <= n;
		last_word <= lst;
		do
			@(posedge clk);
		while (!ready);
		sb.note_word(d, n, lst);
	endtask

	task automatic send_message(int unsigned full_words, logic [3:0] n);
		for (int i = 0; i < full_words; i++)
			send_word($urandom, 4'($urandom_range(15)), 1'b0);
		send_word($urandom, n, 1'b1);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_digest(digest_word, word_index, digest_last);
		if (stall_go && !stall_done) begin
			stall_done <= 1'b1;
			hold_off <= 400;
			out_ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 6);
	end

	always @(posedge clk) begin
		if ((valid && ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000 && !timed_out) begin
			timed_out <= 1'b1;
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned len;
		sb = new();
		sb.start_message();
		valid = 1'b0;
		data_word = '0;
		nibble_count = '0;
		last_word = 1'b0;
		calm_phase = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, every partial nibble count, counts above
		// eight, extreme data, and lengths around the extra padding block.
		send_word(32'hFFFFFFFF, 4'd0, 1'b1);
		send_word(32'h61626300, 4'd6, 1'b1);
		for (int n = 1; n <= 15; n++)
			send_word((n % 2) ? 32'hFFFFFFFF : 32'h0, 4'(n), 1'b1);
		send_message(13, 4'd8);
		send_message(14, 4'd3);
		send_message(15, 4'd8);

		// Long stall of the receiver while words keep coming.
		stall_go <= 1'b1;
		send_message(20, 4'd5);
		send_message(2, 4'd8);

		for (int m = 0; sb.words_taken < 290; m++) begin
			calm_phase = (m >= 10 && m < 16);
			len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(16);
			send_message(len, 4'($urandom_range(15)));
		end
		calm_phase = 1'b0;
		valid <= 1'b0;

		while (sb.pending_digest.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Covered %0d words and %0d digests,", sb.words_taken, sb.digests_seen);
		$display("incl. empty, partial and multi-block messages.");
		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
hdl/sm3_pkg.sv
hdl/sm3_round.sv
hdl/sm3_hash_engine.sv
test/sm3_hash_engine_tb.sv
